>>> rtl/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 1024;

  localparam int BYTE_W    = 8;
  localparam int WIDTH_W   = 11;
  localparam int COUNT_W   = 9;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = CFG_IDX_W'(1);

  // parse phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  // segment type and packed codes
  localparam logic [BYTE_W-1:0] TYPE_LITERAL = 8'hFF;
  localparam logic [2:0]        CODE_LITERAL = 3'd7;
  localparam logic [2:0]        CODE_SKIP    = 3'd6;

  // effective configuration seen by the decoder
  typedef struct packed {
    logic               mode;
    logic [WIDTH_W-1:0] width;
  } cfg_t;

  // one decoded run, emit low when the byte produced nothing
  typedef struct packed {
    logic               emit;
    logic [BYTE_W-1:0]  pixel;
    logic [COUNT_W-1:0] count;
    logic               row_end;
  } run_t;

endpackage

>>> rtl/rrd_cfg.sv
`timescale 1ns / 1ps

module rrd_cfg #(
  parameter int MAX_ROW_WIDTH = rrd_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rrd_pkg::WIDTH_W-1:0]    wr_data,
  output rrd_pkg::cfg_t                  cfg
);
  import rrd_pkg::*;

  // largest width the 11-bit register can reach after clamping
  localparam int WIDTH_MAX_VAL = (1 << WIDTH_W) - 1;
  localparam logic [WIDTH_W-1:0] WIDTH_CAP = (MAX_ROW_WIDTH > WIDTH_MAX_VAL) ?
                                             WIDTH_W'(WIDTH_MAX_VAL) :
                                             WIDTH_W'(MAX_ROW_WIDTH);

  logic               mode_r;
  logic [WIDTH_W-1:0] width_r;
  logic [WIDTH_W-1:0] width_nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      width_r <= WIDTH_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE:  mode_r  <= wr_data[0];
        REG_WIDTH: width_r <= wr_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  assign width_nz  = (width_r == '0) ? WIDTH_W'(1) : width_r;
  assign cfg.mode  = mode_r;
  assign cfg.width = (width_nz > WIDTH_CAP) ? WIDTH_CAP : width_nz;

endmodule

>>> rtl/rrd_decode.sv
`timescale 1ns / 1ps

module rrd_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [rrd_pkg::BYTE_W-1:0]   byte_i,
  input  logic                         start_i,
  input  rrd_pkg::cfg_t                cfg,
  output rrd_pkg::run_t                run
);
  import rrd_pkg::*;

  logic [1:0]         phase_r, phase_nxt;
  logic [BYTE_W-1:0]  pend_r, pend_nxt;
  logic [COUNT_W-1:0] lit_r, lit_nxt;
  logic [WIDTH_W-1:0] pos_r, pos_nxt;
  logic               fin_r, fin_nxt;

  always_comb begin
    logic [1:0]         ph;
    logic [BYTE_W-1:0]  pend;
    logic [COUNT_W-1:0] lit;
    logic [WIDTH_W-1:0] pos;
    logic               fin;
    logic               req;
    logic [BYTE_W-1:0]  req_val;
    logic [COUNT_W-1:0] req_cnt;
    logic [WIDTH_W-1:0] left;
    logic [COUNT_W-1:0] cnt;
    logic [WIDTH_W-1:0] pos_new;

    ph      = phase_r;
    pend    = pend_r;
    lit     = lit_r;
    pos     = pos_r;
    fin     = fin_r;
    req     = 1'b0;
    req_val = '0;
    req_cnt = '0;
    cnt     = '0;
    pos_new = '0;
    run     = '0;

    if (start_i) begin
      ph  = PH_HEADER;
      lit = '0;
      pos = '0;
      fin = 1'b0;
    end

    if (fin) begin
      // rest of the row is ignored
    end else if (pos >= cfg.width) begin
      fin = 1'b1;
    end else if (ph == PH_LITERAL) begin
      if (lit != '0) lit = lit - COUNT_W'(1);
      if (lit == '0) ph = PH_HEADER;
      req     = 1'b1;
      req_val = byte_i;
      req_cnt = COUNT_W'(1);
    end else if (!cfg.mode) begin
      if (ph == PH_LENGTH) begin
        ph = PH_HEADER;
        if (pend == TYPE_LITERAL) begin
          lit = {1'b0, byte_i} + COUNT_W'(1);
          ph  = PH_LITERAL;
        end else begin
          req     = 1'b1;
          req_cnt = {1'b0, byte_i} + COUNT_W'(1);
        end
      end else begin
        pend = byte_i;
        ph   = PH_LENGTH;
      end
    end else begin
      ph = PH_HEADER;
      if (byte_i[7:5] == CODE_LITERAL) begin
        lit = COUNT_W'(byte_i[4:0]) + COUNT_W'(1);
        ph  = PH_LITERAL;
      end else if (byte_i[7:5] != CODE_SKIP) begin
        req     = 1'b1;
        req_val = BYTE_W'(byte_i[7:5]);
        req_cnt = COUNT_W'(byte_i[4:0]) + COUNT_W'(1);
      end
    end

    // clip the run to the pixels left in the row
    left = cfg.width - pos;
    if (req) begin
      cnt         = (WIDTH_W'(req_cnt) > left) ? left[COUNT_W-1:0] : req_cnt;
      pos_new     = pos + WIDTH_W'(cnt);
      pos         = pos_new;
      fin         = (pos_new >= cfg.width);
      run.emit    = 1'b1;
      run.pixel   = req_val;
      run.count   = cnt;
      run.row_end = fin;
    end

    phase_nxt = ph;
    pend_nxt  = pend;
    lit_nxt   = lit;
    pos_nxt   = pos;
    fin_nxt   = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pend_r  <= '0;
      lit_r   <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      lit_r   <= lit_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

>>> rtl/sprite_row_rle_decoder_core.sv
`timescale 1ns / 1ps

// sprite row run-length decoder
// in_*  : compressed byte requests, one byte each, in_tuser flags the first byte of a row
// out_* : decoded run requests (pixel value and count), out_tlast marks the run that
//         completes the row width
// cfg_* : register writes, index 0 compression mode, index 1 row width; always ready;
//         the user must write them only while the decoder is idle, the block does not enforce it
// throughput: one byte per cycle, sustained while the output is not stalled; the parse state
//   (phase, pending type, literal count, row position) updates in the single decode step
//   between the input register and the output register
// path: a byte accepted into the input register gives its run in the output register;
//   header bytes, ignored bytes and code 6 give no run
// reset: synchronous active low, clears both valid flags, the parse state and the
//   registers (mode 0, width 1); decoding then starts as if a row had begun
// stall: when out_tready is low the result holds; one more byte is taken into the
//   input register, after which in_tready drops until the result is taken
module sprite_row_rle_decoder_core #(
  parameter int MAX_ROW_WIDTH = rrd_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // [7:0] data_byte
  input  logic [7:0]                    in_tdata,
  // [0] row_start
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] pixel_value, [16:8] run_count, [23:17] zero
  output logic [23:0]                   out_tdata,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrd_pkg::WIDTH_W-1:0]   cfg_data
);
  import rrd_pkg::*;

  cfg_t cfg;
  run_t run;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_pixel_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_end_r;

  logic in_acc;
  logic out_free;
  logic adv;

  assign cfg_ready = 1'b1;

  // the output slot frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  rrd_cfg #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rrd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_i  (s1_byte_r),
    .start_i (s1_start_r),
    .cfg     (cfg),
    .run     (run)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = run.emit;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (adv && run.emit) begin
      out_pixel_r <= run.pixel;
      out_count_r <= run.count;
      out_end_r   <= run.row_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_count_r, out_pixel_r};
  assign out_tlast  = out_end_r;

endmodule

>>> rtl/rrd_checker.sv
`timescale 1ns / 1ps

module rrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a run always covers at least one pixel and never more than 256
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:8] != 9'd0 && out_tdata[16:8] <= 9'd256)
    else $error("run count out of range");

  // a literal pixel run is a single pixel, so a multi-pixel run only carries fill codes 0 to 5
  a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16:8] != 9'd1 |-> out_tdata[7:0] <= 8'd5)
    else $error("multi-pixel run with literal value");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("nonzero padding in result");

  // reset leaves no result pending and config open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_ready)
    else $error("result pending after reset");

endmodule

bind sprite_row_rle_decoder_core rrd_checker u_rrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_ready  (cfg_ready)
);
